// ===== sv/att_pkg.sv =====
// Shared types and constants for the assembly text tokenizer.
package att_pkg;

   localparam logic [2:0] MODE_NORMAL  = 3'd0;
   localparam logic [2:0] MODE_COMMENT = 3'd1;
   localparam logic [2:0] MODE_NAME    = 3'd2;
   localparam logic [2:0] MODE_NUMBER  = 3'd3;
   localparam logic [2:0] MODE_EXP     = 3'd4;
   localparam logic [2:0] MODE_EXPSIGN = 3'd5;

   localparam logic [1:0] NAME_PLAIN    = 2'd0;
   localparam logic [1:0] NAME_SYMBOL   = 2'd1;
   localparam logic [1:0] NAME_REGISTER = 2'd2;
   localparam logic [1:0] NAME_LABEL    = 2'd3;

   localparam logic [3:0] TT_SYMBOL   = 4'd9;
   localparam logic [3:0] TT_REGISTER = 4'd10;
   localparam logic [3:0] TT_LABEL    = 4'd11;
   localparam logic [3:0] TT_IDENT    = 4'd12;
   localparam logic [3:0] TT_INT      = 4'd13;
   localparam logic [3:0] TT_FLOAT    = 4'd14;
   localparam logic [3:0] TT_EOF      = 4'd15;

   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_TOKEN  = 1'b1;

   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_LOW_E   = 8'h65;
   localparam logic [7:0] CH_UP_E    = 8'h45;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_BITS = 2;

   typedef struct packed {
      logic        kind;
      logic [7:0]  char_out;
      logic [3:0]  token_type;
      logic [15:0] start_row;
      logic [11:0] start_column;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } step_type;

   // Punctuation type for a byte, TT_EOF when the byte is not punctuation.
   function automatic logic [3:0] punct_type(input logic [7:0] c);
      logic [3:0] t;
      case (c)
         8'h3D:   t = 4'd0;
         8'h2C:   t = 4'd1;
         8'h2A:   t = 4'd2;
         8'h28:   t = 4'd3;
         8'h29:   t = 4'd4;
         8'h7B:   t = 4'd5;
         8'h7D:   t = 4'd6;
         8'h5B:   t = 4'd7;
         8'h5D:   t = 4'd8;
         default: t = TT_EOF;
      endcase
      return t;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_name_start(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER};
   endfunction

endpackage

// ===== sv/assembly_text_tokenizer.sv =====
// Top level of the assembly text tokenizer.
//   channel   ports   direction   transaction
//   request   req_*   in          one source byte or end of input
//   response  rsp_*   out         one appended character or finished token
// One byte per cycle while the queue has room: each byte is registered, then decoded
// against the lexer state, and its 0 to 2 results go to a four-entry queue whose head
// is the response output. A byte moves on only while the queue holds two or fewer
// results, so two-result bytes back to back are slowed by the queue's single output,
// and a stalled result side stops the request side.
// Reset is synchronous, active high, and clears the lexer state and the queue.
module assembly_text_tokenizer #(
   parameter int ROW_BITS = 16,
   parameter int COLUMN_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_flag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_char_out,
   output logic [3:0]  rsp_token_type,
   output logic [15:0] rsp_start_row,
   output logic [11:0] rsp_start_column,
   output logic        rsp_last
);
   import att_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_end_ff;
   logic       room, fire;
   step_type   step;
   rsp_type    rsp;

   assign fire        = s1_valid_ff && room;
   assign req_ready   = !s1_valid_ff || fire;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_char_ff <= req_char_in;
         s1_end_ff  <= req_end_flag;
      end
   end

   att_lexer #(
      .ROW_BITS(ROW_BITS),
      .COLUMN_BITS(COLUMN_BITS)
   ) u_lexer (
      .clock(clock),
      .reset(reset),
      .step_en(fire),
      .char_in(s1_char_ff),
      .end_flag(s1_end_ff),
      .step(step)
   );

   att_rsp_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push_en(fire),
      .step(step),
      .room(room),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp(rsp)
   );

   assign rsp_kind         = rsp.kind;
   assign rsp_char_out     = rsp.char_out;
   assign rsp_token_type   = rsp.token_type;
   assign rsp_start_row    = rsp.start_row;
   assign rsp_start_column = rsp.start_column;
   assign rsp_last         = rsp.last;

endmodule

// ===== sv/att_lexer.sv =====
// Lexer state and the per-character step producing up to two results.
module att_lexer #(
   parameter int ROW_BITS = 16,
   parameter int COLUMN_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [7:0]        char_in,
   input  logic              end_flag,
   output att_pkg::step_type step
);
   import att_pkg::*;

   logic [2:0]             mode_ff, mode_in;
   logic [1:0]             name_kind_ff, name_kind_in;
   logic                   float_ff, float_in;
   logic [ROW_BITS-1:0]    token_row_ff, token_row_in;
   logic [COLUMN_BITS-1:0] token_col_ff, token_col_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;

   logic [COLUMN_BITS-1:0] col_inc;
   logic [ROW_BITS-1:0]    row_inc;
   logic [ROW_BITS+15:0]   row_ext, token_row_ext;
   logic [COLUMN_BITS+11:0] col_ext, token_col_ext;
   logic [3:0]             p_type;
   rsp_type                fin, nrm;
   logic                   fin_v, nrm_v, renorm;

   assign col_inc = (col_ff != '1) ? col_ff + 1'b1 : col_ff;
   assign row_inc = (row_ff != '1) ? row_ff + 1'b1 : row_ff;
   assign row_ext = {16'b0, row_ff};
   assign token_row_ext = {16'b0, token_row_ff};
   assign col_ext = {12'b0, col_inc};
   assign token_col_ext = {12'b0, token_col_ff};
   assign p_type = punct_type(char_in);

   always_comb begin
      mode_in      = mode_ff;
      name_kind_in = name_kind_ff;
      float_in     = float_ff;
      token_row_in = token_row_ff;
      token_col_in = token_col_ff;
      row_in       = row_ff;
      col_in       = col_inc;
      fin_v        = 1'b0;
      nrm_v        = 1'b0;
      renorm       = 1'b0;
      nrm          = '0;

      fin = '0;
      fin.kind = KIND_TOKEN;
      fin.start_row = token_row_ext[15:0];
      fin.start_column = token_col_ext[11:0];
      if (mode_ff == MODE_NAME) begin
         case (name_kind_ff)
            NAME_SYMBOL:   fin.token_type = TT_SYMBOL;
            NAME_REGISTER: fin.token_type = TT_REGISTER;
            NAME_LABEL:    fin.token_type = TT_LABEL;
            default:       fin.token_type = TT_IDENT;
         endcase
      end else begin
         fin.token_type = float_ff ? TT_FLOAT : TT_INT;
      end

      if (end_flag) begin
         fin_v = mode_ff inside {MODE_NAME, MODE_NUMBER, MODE_EXP, MODE_EXPSIGN};
         nrm_v = 1'b1;
         nrm.kind = KIND_TOKEN;
         nrm.token_type = TT_EOF;
         nrm.start_row = row_ext[15:0];
         nrm.start_column = col_ext[11:0];
         mode_in = MODE_NORMAL;
      end else begin
         case (mode_ff)
            MODE_COMMENT: begin
               if (char_in == CH_NEWLINE) begin
                  col_in  = '0;
                  row_in  = row_inc;
                  mode_in = MODE_NORMAL;
               end
            end
            MODE_NAME: begin
               if (is_digit(char_in) || is_name_start(char_in)) begin
                  nrm_v = 1'b1;
                  nrm.char_out = char_in;
               end else begin
                  fin_v  = 1'b1;
                  renorm = 1'b1;
               end
            end
            MODE_NUMBER, MODE_EXP, MODE_EXPSIGN: begin
               if (mode_ff == MODE_NUMBER &&
                   (char_in == CH_LOW_E || char_in == CH_UP_E)) begin
                  float_in = 1'b1;
                  mode_in  = MODE_EXP;
                  nrm_v    = 1'b1;
                  nrm.char_out = char_in;
               end else if (mode_ff == MODE_EXP && char_in == CH_MINUS) begin
                  mode_in = MODE_EXPSIGN;
                  nrm_v   = 1'b1;
                  nrm.char_out = char_in;
               end else if (is_digit(char_in)) begin
                  mode_in = MODE_NUMBER;
                  nrm_v   = 1'b1;
                  nrm.char_out = char_in;
               end else if (char_in == CH_DOT) begin
                  float_in = 1'b1;
                  mode_in  = MODE_NUMBER;
                  nrm_v    = 1'b1;
                  nrm.char_out = char_in;
               end else begin
                  fin_v  = 1'b1;
                  renorm = 1'b1;
               end
            end
            default: renorm = 1'b1;
         endcase

         if (renorm) begin
            mode_in = MODE_NORMAL;
            if (char_in == CH_NEWLINE) begin
               col_in = '0;
               row_in = row_inc;
            end else if (char_in == CH_HASH) begin
               mode_in = MODE_COMMENT;
            end else if (char_in inside {CH_AT, CH_PERCENT, CH_DOLLAR}) begin
               token_row_in = row_ff;
               token_col_in = col_inc;
               mode_in      = MODE_NAME;
               if (char_in == CH_AT) name_kind_in = NAME_SYMBOL;
               else if (char_in == CH_PERCENT) name_kind_in = NAME_REGISTER;
               else name_kind_in = NAME_LABEL;
            end else if (p_type != TT_EOF) begin
               nrm_v = 1'b1;
               nrm.kind = KIND_TOKEN;
               nrm.char_out = char_in;
               nrm.token_type = p_type;
               nrm.start_row = row_ext[15:0];
               nrm.start_column = col_ext[11:0];
            end else if (is_digit(char_in)) begin
               token_row_in = row_ff;
               token_col_in = col_inc;
               float_in     = 1'b0;
               mode_in      = MODE_NUMBER;
               nrm_v        = 1'b1;
               nrm.char_out = char_in;
            end else if (is_name_start(char_in)) begin
               token_row_in = row_ff;
               token_col_in = col_inc;
               name_kind_in = NAME_PLAIN;
               mode_in      = MODE_NAME;
               nrm_v        = 1'b1;
               nrm.char_out = char_in;
            end
         end
      end

      step = '0;
      if (fin_v) begin
         step.first  = fin;
         step.second = nrm;
         step.count  = nrm_v ? 2'd2 : 2'd1;
         if (nrm_v) step.second.last = 1'b1;
         else step.first.last = 1'b1;
      end else begin
         step.first = nrm;
         step.first.last = 1'b1;
         step.count = {1'b0, nrm_v};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         name_kind_ff <= NAME_PLAIN;
         float_ff     <= 1'b0;
         token_row_ff <= '0;
         token_col_ff <= '0;
         row_ff       <= ROW_BITS'(1);
         col_ff       <= '0;
      end else if (step_en) begin
         mode_ff      <= mode_in;
         name_kind_ff <= name_kind_in;
         float_ff     <= float_in;
         token_row_ff <= token_row_in;
         token_col_ff <= token_col_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

endmodule

// ===== sv/att_rsp_fifo.sv =====
// Result queue taking up to two results per cycle and giving one.
module att_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_en,
   input  att_pkg::step_type step,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output att_pkg::rsp_type  rsp
);
   import att_pkg::*;

   rsp_type                 mem_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [RSP_PTR_BITS:0]   count_ff, count_in;
   logic                    pop;
   logic [1:0]              n_push;

   assign pop       = rsp_valid && rsp_ready;
   assign n_push    = push_en ? step.count : 2'd0;
   assign rsp_valid = (count_ff != '0);
   assign rsp       = mem_ff[rd_ff];
   assign room      = (count_ff <= (RSP_PTR_BITS+1)'(RSP_DEPTH - 2));
   assign wr_next   = wr_ff + 1'b1;
   assign wr_in     = wr_ff + RSP_PTR_BITS'(n_push);
   assign rd_in     = rd_ff + RSP_PTR_BITS'(pop);
   assign count_in  = count_ff + (RSP_PTR_BITS+1)'(n_push) - (RSP_PTR_BITS+1)'(pop);

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) mem_ff[wr_ff] <= step.first;
      if (n_push == 2'd2) mem_ff[wr_next] <= step.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/att_checker.sv =====
// Port-level checks for the assembly text tokenizer, bound to the top level.
module att_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [7:0]  rsp_char_out,
   input logic [3:0]  rsp_token_type,
   input logic [15:0] rsp_start_row,
   input logic [11:0] rsp_start_column,
   input logic        rsp_last
);
   import att_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_append_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_APPEND |->
         rsp_token_type == 4'd0 && rsp_start_row == 16'd0 && rsp_start_column == 12'd0)
      else $error("append transaction carries token fields");

   a_append_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_APPEND |-> rsp_last)
      else $error("append transaction not last of its byte");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_TOKEN && rsp_token_type == TT_EOF |->
         rsp_last && rsp_char_out == 8'd0)
      else $error("end-of-file token malformed");

endmodule

bind assembly_text_tokenizer att_checker u_att_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_kind(rsp_kind),
   .rsp_char_out(rsp_char_out),
   .rsp_token_type(rsp_token_type),
   .rsp_start_row(rsp_start_row),
   .rsp_start_column(rsp_start_column),
   .rsp_last(rsp_last)
);

// ===== verif/tb_assembly_text_tokenizer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the assembly text tokenizer: directed and random source text.
module tb_assembly_text_tokenizer;
   import att_pkg::*;

   localparam int GAP_MAX = 18;
   localparam int PRINT_LIMIT = 40;
   localparam int RANDOM_ITEMS = 600;
   localparam int NOT_PUNCT = 9;
   localparam logic [71:0] PUNCT_TEXT = "=,*(){}[]";
   localparam logic [23:0] SIGIL_TEXT = {CH_AT, CH_PERCENT, CH_DOLLAR};
   localparam logic [31:0] BLANK_TEXT = {8'h20, 8'h09, CH_MINUS, CH_DOT};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = 8'h00;
   logic        req_end_flag = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_char_out;
   logic [3:0]  rsp_token_type;
   logic [15:0] rsp_start_row;
   logic [11:0] rsp_start_column;
   logic        rsp_last;

   rsp_type     lexed_results[$];
   rsp_type     step_results[$];

   logic [2:0]  lx_mode;
   logic [1:0]  lx_name_kind;
   logic        lx_float;
   logic [15:0] lx_tok_row;
   logic [11:0] lx_tok_col;
   logic [15:0] lx_row;
   logic [11:0] lx_col;

   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned req_gap_max = 0;
   int unsigned rsp_gap_max = 0;
   int unsigned rsp_hold_cycles = 0;
   int unsigned rsp_stall_left = 0;

   assembly_text_tokenizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .req_end_flag     (req_end_flag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_char_out     (rsp_char_out),
      .rsp_token_type   (rsp_token_type),
      .rsp_start_row    (rsp_start_row),
      .rsp_start_column (rsp_start_column),
      .rsp_last         (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- lexer predictor

   function automatic logic is_dec(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [7:0] punct_char(input int unsigned idx);
      return PUNCT_TEXT[71 - 8 * idx -: 8];
   endfunction

   function automatic int unsigned punct_code(input logic [7:0] c);
      for (int unsigned i = 0; i < 9; i++)
         if (punct_char(i) == c)
            return i;
      return NOT_PUNCT;
   endfunction

   task automatic lexer_reset();
      lx_mode = MODE_NORMAL;
      lx_name_kind = NAME_PLAIN;
      lx_float = 1'b0;
      lx_tok_row = '0;
      lx_tok_col = '0;
      lx_row = 16'd1;
      lx_col = '0;
   endtask

   task automatic add_result(input logic kind, input logic [7:0] ch, input logic [3:0] tt,
                             input logic [15:0] row, input logic [11:0] col);
      rsp_type r;
      r.kind = kind;
      r.char_out = ch;
      r.token_type = tt;
      r.start_row = row;
      r.start_column = col;
      r.last = 1'b0;
      step_results.push_back(r);
   endtask

   task automatic new_row();
      lx_col = '0;
      if (lx_row != '1)
         lx_row++;
   endtask

   task automatic mark_token_start();
      lx_tok_row = lx_row;
      lx_tok_col = lx_col;
   endtask

   task automatic close_token();
      logic [3:0] tt;
      if (lx_mode == MODE_NAME) begin
         case (lx_name_kind)
            NAME_SYMBOL:   tt = TT_SYMBOL;
            NAME_REGISTER: tt = TT_REGISTER;
            NAME_LABEL:    tt = TT_LABEL;
            default:       tt = TT_IDENT;
         endcase
         add_result(KIND_TOKEN, 8'h00, tt, lx_tok_row, lx_tok_col);
      end else if (lx_mode == MODE_NUMBER || lx_mode == MODE_EXP || lx_mode == MODE_EXPSIGN) begin
         add_result(KIND_TOKEN, 8'h00, lx_float ? TT_FLOAT : TT_INT, lx_tok_row, lx_tok_col);
      end
      lx_mode = MODE_NORMAL;
   endtask

   task automatic lex_normal(input logic [7:0] c);
      int unsigned pc;
      pc = punct_code(c);
      lx_mode = MODE_NORMAL;
      if (c == CH_NEWLINE) begin
         new_row();
      end else if (c == CH_HASH) begin
         lx_mode = MODE_COMMENT;
      end else if (c == CH_AT || c == CH_PERCENT || c == CH_DOLLAR) begin
         mark_token_start();
         lx_name_kind = (c == CH_AT) ? NAME_SYMBOL : (c == CH_PERCENT) ? NAME_REGISTER : NAME_LABEL;
         lx_mode = MODE_NAME;
      end else if (pc != NOT_PUNCT) begin
         add_result(KIND_TOKEN, c, pc[3:0], lx_row, lx_col);
      end else if (is_dec(c)) begin
         mark_token_start();
         lx_float = 1'b0;
         lx_mode = MODE_NUMBER;
         add_result(KIND_APPEND, c, 4'd0, 16'd0, 12'd0);
      end else if (is_letter(c) || c == CH_UNDER) begin
         mark_token_start();
         lx_name_kind = NAME_PLAIN;
         lx_mode = MODE_NAME;
         add_result(KIND_APPEND, c, 4'd0, 16'd0, 12'd0);
      end
   endtask

   task automatic lex_step(input logic [7:0] c, input logic eoi);
      rsp_type r;
      step_results.delete();
      if (lx_col != '1)
         lx_col++;
      if (eoi) begin
         close_token();
         add_result(KIND_TOKEN, 8'h00, TT_EOF, lx_row, lx_col);
      end else begin
         case (lx_mode)
            MODE_COMMENT: begin
               if (c == CH_NEWLINE) begin
                  new_row();
                  lx_mode = MODE_NORMAL;
               end
            end
            MODE_NAME: begin
               if (is_dec(c) || is_letter(c) || c == CH_UNDER) begin
                  add_result(KIND_APPEND, c, 4'd0, 16'd0, 12'd0);
               end else begin
                  close_token();
                  lex_normal(c);
               end
            end
            MODE_NUMBER, MODE_EXP, MODE_EXPSIGN: begin
               if (lx_mode == MODE_NUMBER && (c == CH_LOW_E || c == CH_UP_E)) begin
                  lx_float = 1'b1;
                  lx_mode = MODE_EXP;
                  add_result(KIND_APPEND, c, 4'd0, 16'd0, 12'd0);
               end else if (lx_mode == MODE_EXP && c == CH_MINUS) begin
                  lx_mode = MODE_EXPSIGN;
                  add_result(KIND_APPEND, c, 4'd0, 16'd0, 12'd0);
               end else if (is_dec(c)) begin
                  lx_mode = MODE_NUMBER;
                  add_result(KIND_APPEND, c, 4'd0, 16'd0, 12'd0);
               end else if (c == CH_DOT) begin
                  lx_float = 1'b1;
                  lx_mode = MODE_NUMBER;
                  add_result(KIND_APPEND, c, 4'd0, 16'd0, 12'd0);
               end else begin
                  close_token();
                  lex_normal(c);
               end
            end
            default: lex_normal(c);
         endcase
      end
      if (step_results.size() > 0) begin
         r = step_results.pop_back();
         r.last = 1'b1;
         step_results.push_back(r);
      end
      foreach (step_results[i])
         lexed_results.push_back(step_results[i]);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (error_count < PRINT_LIMIT)
         $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_kind, rsp_char_out, rsp_token_type, rsp_start_row, rsp_start_column,
                rsp_last};
         rsp_stall_left = $urandom_range(0, rsp_gap_max);
         if (lexed_results.size() == 0) begin
            report_mismatch("unexpected transaction", 16'(got.char_out), 16'd0);
         end else begin
            want = lexed_results.pop_front();
            if (got.kind !== want.kind)
               report_mismatch("kind", 16'(got.kind), 16'(want.kind));
            if (got.char_out !== want.char_out)
               report_mismatch("char_out", 16'(got.char_out), 16'(want.char_out));
            if (got.token_type !== want.token_type)
               report_mismatch("token_type", 16'(got.token_type), 16'(want.token_type));
            if (got.start_row !== want.start_row)
               report_mismatch("start_row", got.start_row, want.start_row);
            if (got.start_column !== want.start_column)
               report_mismatch("start_column", 16'(got.start_column),
                               16'(want.start_column));
            if (got.last !== want.last)
               report_mismatch("last", 16'(got.last), 16'(want.last));
         end
      end
   end

   // long hold-offs and per-transaction stalls on the result side
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = rsp_stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_item(input logic [7:0] c, input logic eoi);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      req_end_flag <= eoi;
      do @(posedge clock); while (!req_ready);
      lex_step(c, eoi);
      items_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++)
         send_item(text[i], 1'b0);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (lexed_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_digit();
      logic [7:0] r;
      r = 8'($urandom_range(0, 9));
      return "0" + r;
   endfunction

   function automatic logic [7:0] random_name_start();
      logic [7:0] r;
      r = 8'($urandom_range(0, 52));
      if (r < 8'd26)
         return "a" + r;
      if (r < 8'd52)
         return "A" + r - 8'd26;
      return CH_UNDER;
   endfunction

   function automatic logic [7:0] random_name_char();
      logic [7:0] r;
      r = 8'($urandom_range(0, 62));
      if (r < 8'd10)
         return "0" + r;
      if (r < 8'd36)
         return "a" + r - 8'd10;
      if (r < 8'd62)
         return "A" + r - 8'd36;
      return CH_UNDER;
   endfunction

   task automatic send_random_token();
      int unsigned pick;
      int unsigned idx;
      pick = $urandom_range(0, 11);
      case (pick)
         0: send_item(punct_char($urandom_range(0, 8)), 1'b0);
         1: begin
            idx = $urandom_range(0, 2);
            send_item(SIGIL_TEXT[23 - 8 * idx -: 8], 1'b0);
            repeat ($urandom_range(0, 5)) send_item(random_name_char(), 1'b0);
         end
         2, 3: begin
            send_item(random_name_start(), 1'b0);
            repeat ($urandom_range(0, 6)) send_item(random_name_char(), 1'b0);
         end
         4, 5: repeat ($urandom_range(1, 6)) send_item(random_digit(), 1'b0);
         6: begin
            repeat ($urandom_range(1, 3)) send_item(random_digit(), 1'b0);
            if ($urandom_range(0, 1)) begin
               send_item(CH_DOT, 1'b0);
               repeat ($urandom_range(0, 3)) send_item(random_digit(), 1'b0);
            end
            if ($urandom_range(0, 1)) begin
               send_item($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E, 1'b0);
               if ($urandom_range(0, 1))
                  send_item(CH_MINUS, 1'b0);
               repeat ($urandom_range(0, 3)) send_item(random_digit(), 1'b0);
            end
         end
         7: begin
            send_item(CH_HASH, 1'b0);
            repeat ($urandom_range(0, 8)) send_item(8'($urandom_range(0, 255)), 1'b0);
            send_item(CH_NEWLINE, 1'b0);
         end
         8: send_item(CH_NEWLINE, 1'b0);
         9: begin
            idx = $urandom_range(0, 3);
            send_item(BLANK_TEXT[31 - 8 * idx -: 8], 1'b0);
         end
         10: send_item(8'($urandom_range(0, 255)), 1'b0);
         default: begin
            if ($urandom_range(0, 3) == 0)
               send_item(8'($urandom_range(0, 255)), 1'b1);
            else
               send_item(CH_NEWLINE, 1'b0);
         end
      endcase
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_punctuation();
      send_text("=,*(){}[]\n");
      wait_drained();
   endtask

   // sigil names, empty names, and a terminator that is itself a token
   task automatic test_prefixed_names();
      send_text("@sym%r1$ _x9 @(\n");
      wait_drained();
   endtask

   // exponent letters are not rechecked right after the exponent or its sign
   task automatic test_numbers();
      send_text("42 1.5e-3E 9e-e 8ee\n");
      wait_drained();
   endtask

   task automatic test_comments();
      send_text("a#x=1\n");
      wait_drained();
   endtask

   task automatic test_end_of_input();
      send_text("ab");
      send_item(8'hFF, 1'b1);
      send_text("4e-");
      send_item(8'h00, 1'b1);
      send_item(8'h5A, 1'b1);
      send_text("#c");
      send_item(8'hA5, 1'b1);
      send_item(CH_PERCENT, 1'b0);
      send_item(8'h3D, 1'b1);
      wait_drained();
   endtask

   task automatic test_unused_bytes();
      send_item(8'h00, 1'b0);
      send_item(8'h7F, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text("-.q");
      send_item(8'hFF, 1'b0);
      send_item("5", 1'b0);
      send_item(8'h00, 1'b0);
      wait_drained();
   endtask

   // hold the result side off while bytes keep coming, so the input stalls
   task automatic test_output_backpressure();
      req_gap_max = 0;
      rsp_hold_cycles = 150;
      repeat (30) send_item(punct_char($urandom_range(0, 8)), 1'b0);
      wait_drained();
   endtask

   task automatic test_random_source();
      int unsigned first;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         case ((items_sent - first) / (RANDOM_ITEMS / 4))
            0: begin
               req_gap_max = GAP_MAX;
               rsp_gap_max = GAP_MAX;
            end
            1: begin
               req_gap_max = 0;
               rsp_gap_max = 0;
            end
            2: begin
               req_gap_max = 0;
               rsp_gap_max = GAP_MAX;
            end
            default: begin
               req_gap_max = GAP_MAX;
               rsp_gap_max = 0;
            end
         endcase
         send_random_token();
      end
      wait_drained();
   endtask

   initial begin
      int unsigned waited;
      lexer_reset();
      req_gap_max = 6;
      rsp_gap_max = 6;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_punctuation();
      test_prefixed_names();
      test_numbers();
      test_comments();
      test_end_of_input();
      test_unused_bytes();
      test_output_backpressure();
      test_random_source();

      waited = 0;
      while (lexed_results.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (lexed_results.size() != 0)
         report_mismatch("missing transactions", 16'(lexed_results.size()), 16'd0);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/att_pkg.sv
sv/att_lexer.sv
sv/att_rsp_fifo.sv
sv/assembly_text_tokenizer.sv
sv/att_checker.sv
verif/tb_assembly_text_tokenizer.sv
